// ----- design/approximate_substring_matcher_core_defines.svh -----
// Assertion helpers shared by the matcher RTL.
`ifndef APPROXIMATE_SUBSTRING_MATCHER_CORE_DEFINES_SVH
`define APPROXIMATE_SUBSTRING_MATCHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asm assertion failed");
// next-cycle implication
`define ASM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("asm assertion failed");
`else
`define ASM_ASSERT_NOW(lbl, ante, cons)
`define ASM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/asm_pkg.sv -----
`default_nettype none

package asm_pkg;

  localparam int ASM_PATTERN_MAX    = 32;
  localparam int ASM_ERRORS_MAX     = 8;
  localparam int ASM_POSITION_WIDTH = 16;

  localparam int ASM_PATTERN_REGS = 4;
  localparam int ASM_BYTES_PER_REG = 8;
  localparam int ASM_CFG_IDX_W    = 3;
  localparam int ASM_CFG_DATA_W   = 64;
  localparam int ASM_LEN_W        = 6;
  localparam int ASM_ERR_W        = 4;

  typedef logic [ASM_CFG_DATA_W-1:0] asm_pat_word_t;

  typedef enum logic [ASM_CFG_IDX_W-1:0] {
    ASM_CFG_PAT0 = 3'd0,
    ASM_CFG_PAT1 = 3'd1,
    ASM_CFG_PAT2 = 3'd2,
    ASM_CFG_PAT3 = 3'd3,
    ASM_CFG_LEN  = 3'd4,
    ASM_CFG_ERR  = 3'd5
  } asm_cfg_idx_t;

endpackage

`default_nettype wire

// ----- design/asm_stream_ifs.sv -----
`default_nettype none

interface asm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_of_string;

  modport source (output valid, output text_byte, output last_of_string, input ready);
  modport sink   (input valid, input text_byte, input last_of_string, output ready);
endinterface

interface asm_out_if #(
  parameter int POS_W = 16
);
  logic             valid;
  logic             ready;
  logic             match_here;
  logic             match_seen;
  logic [POS_W-1:0] first_match_position;
  logic             string_done;

  modport source (output valid, output match_here, output match_seen,
                  output first_match_position, output string_done, input ready);
  modport sink   (input valid, input match_here, input match_seen,
                  input first_match_position, input string_done, output ready);
endinterface

`default_nettype wire

// ----- design/asm_char_mask.sv -----
`default_nettype none

module asm_char_mask import asm_pkg::*; #(
  parameter int PATTERN_MAX = ASM_PATTERN_MAX,
  parameter int LW          = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic [7:0]          text_byte,
  input  wire asm_pat_word_t       pat_words [ASM_PATTERN_REGS],
  input  wire logic [LW-1:0]       used_len,
  output      logic [PATTERN_MAX-1:0] cmask
);

  localparam int HELD_BYTES = ASM_PATTERN_REGS * ASM_BYTES_PER_REG;

  // one comparator per pattern position; positions past the held bytes compare to zero
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    if (i < HELD_BYTES) begin : g_held
      assign cmask[i] = (LW'(i) < used_len) &&
        (pat_words[i / ASM_BYTES_PER_REG][(i % ASM_BYTES_PER_REG) * 8 +: 8] == text_byte);
    end else begin : g_zero
      assign cmask[i] = (LW'(i) < used_len) && (text_byte == 8'd0);
    end
  end

endmodule

`default_nettype wire

// ----- design/asm_row_update.sv -----
`default_nettype none
`include "approximate_substring_matcher_core_defines.svh"

module asm_row_update import asm_pkg::*; #(
  parameter int PATTERN_MAX    = ASM_PATTERN_MAX,
  parameter int ERRORS_MAX     = ASM_ERRORS_MAX,
  parameter int POSITION_WIDTH = ASM_POSITION_WIDTH,
  parameter int IW             = $clog2(PATTERN_MAX),
  parameter int KW             = $clog2(ERRORS_MAX + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fire,
  input  wire logic [PATTERN_MAX-1:0]    cmask,
  input  wire logic                      last,
  input  wire logic [IW-1:0]             tail_idx,
  input  wire logic [KW-1:0]             err_k,
  output      logic                      match_here,
  output      logic                      match_seen,
  output      logic [POSITION_WIDTH-1:0] first_pos
);

  localparam int ROWS = ERRORS_MAX + 1;
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  logic [PATTERN_MAX-1:0]    rows_r   [ROWS];
  logic [PATTERN_MAX-1:0]    rows_nxt [ROWS];
  logic [PATTERN_MAX-1:0]    row_init [ROWS];
  logic [POSITION_WIDTH-1:0] pos_r;
  logic [POSITION_WIDTH-1:0] first_r;
  logic                      found_r;

  // row d starts with its low d bits set
  always_comb begin
    for (int d = 0; d < ROWS; d++) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        row_init[d][j] = (j < d);
      end
    end
  end

  // shift-and with insert/delete/substitute terms rippling up from row 0
  always_comb begin
    rows_nxt[0] = {rows_r[0][PATTERN_MAX-2:0], 1'b1} & cmask;
    for (int d = 1; d < ROWS; d++) begin
      rows_nxt[d] = ({rows_r[d][PATTERN_MAX-2:0], 1'b1} & cmask)
                  | {rows_r[d-1][PATTERN_MAX-2:0] | rows_nxt[d-1][PATTERN_MAX-2:0], 1'b1}
                  | rows_r[d-1];
    end
  end

  assign match_here = rows_nxt[err_k][tail_idx];
  assign match_seen = found_r | match_here;
  assign first_pos  = found_r ? first_r : (match_here ? pos_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= row_init;
      pos_r   <= '0;
      first_r <= '0;
      found_r <= 1'b0;
    end else if (fire) begin
      if (last) begin
        rows_r  <= row_init;
        pos_r   <= '0;
        first_r <= '0;
        found_r <= 1'b0;
      end else begin
        rows_r  <= rows_nxt;
        pos_r   <= (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
        first_r <= first_pos;
        found_r <= match_seen;
      end
    end
  end

  `ASM_ASSERT_NEXT(a_string_restart, fire && last, pos_r == '0 && !found_r && first_r == '0)
  `ASM_ASSERT_NOW(a_first_not_ahead, found_r, first_r <= pos_r)

endmodule

`default_nettype wire

// ----- design/approximate_substring_matcher_core.sv -----
// Approximate substring matcher: finds a configured pattern of up to PATTERN_MAX
// bytes in a byte stream, allowing up to error_limit edit errors.
// Configuration: write pattern words, pattern_length and error_limit through the
// cfg_ port while no text is in flight; a write to index 6 or 7 is dropped.
// Input channel in_stream: one text byte per beat, last_of_string on the final
// byte of a string. Output channel out_stream: one result per input beat, in
// order: match_here, match_seen, first_match_position and string_done.
// A byte taken on in_stream passes through the input register, then the result
// register, before its result is shown on out_stream.
// Throughput: one byte per cycle unless out_stream stalls. The byte compare feeds
// the input register; the error-row update, rippling through ERRORS_MAX + 1 rows,
// feeds the result register. A stalled receiver holds the result register; one
// more byte is still taken if the input register is empty, then in_stream.ready drops.
// Reset (rst_n low, synchronous) empties both registers, clears the pattern,
// sets pattern_length to 1 and error_limit to 0, and starts a new string.
`default_nettype none
`include "approximate_substring_matcher_core_defines.svh"

module approximate_substring_matcher_core import asm_pkg::*; #(
  parameter int PATTERN_MAX    = ASM_PATTERN_MAX,
  parameter int ERRORS_MAX     = ASM_ERRORS_MAX,
  parameter int POSITION_WIDTH = ASM_POSITION_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  asm_in_if.sink                         in_stream,
  asm_out_if.source                      out_stream,
  input  wire logic                      cfg_we,
  input  wire logic [ASM_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ASM_CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int IW = $clog2(PATTERN_MAX);
  localparam int KW = $clog2(ERRORS_MAX + 1);
  localparam logic [ASM_LEN_W:0] LEN_CAP = (ASM_LEN_W + 1)'(PATTERN_MAX);
  localparam logic [ASM_ERR_W:0] ERR_CAP = (ASM_ERR_W + 1)'(ERRORS_MAX);

  asm_pat_word_t        pat_r [ASM_PATTERN_REGS];
  logic [ASM_LEN_W-1:0] len_r;
  logic [ASM_ERR_W-1:0] err_r;

  logic [LW-1:0] used_len;
  logic [IW-1:0] tail_idx;
  logic [KW-1:0] err_k;

  logic [PATTERN_MAX-1:0] cmask;
  logic [PATTERN_MAX-1:0] in_mask_r;
  logic                   in_last_r;
  logic                   in_valid_r;

  logic                      out_valid_r;
  logic                      out_here_r;
  logic                      out_seen_r;
  logic [POSITION_WIDTH-1:0] out_first_r;
  logic                      out_done_r;

  logic                      advance;
  logic                      fire;
  logic                      in_ready;
  logic                      row_here;
  logic                      row_seen;
  logic [POSITION_WIDTH-1:0] row_first;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ASM_PATTERN_REGS; r++) begin
        pat_r[r] <= '0;
      end
      len_r <= ASM_LEN_W'(1);
      err_r <= '0;
    end else if (cfg_we) begin
      unique case (asm_cfg_idx_t'(cfg_index))
        ASM_CFG_PAT0: pat_r[0] <= cfg_data;
        ASM_CFG_PAT1: pat_r[1] <= cfg_data;
        ASM_CFG_PAT2: pat_r[2] <= cfg_data;
        ASM_CFG_PAT3: pat_r[3] <= cfg_data;
        ASM_CFG_LEN:  len_r    <= cfg_data[ASM_LEN_W-1:0];
        ASM_CFG_ERR:  err_r    <= cfg_data[ASM_ERR_W-1:0];
        default:      ;
      endcase
    end
  end

  // zero length acts as one; both limits saturate
  always_comb begin
    if (len_r == '0) begin
      used_len = LW'(1);
    end else if ({1'b0, len_r} > LEN_CAP) begin
      used_len = LW'(PATTERN_MAX);
    end else begin
      used_len = LW'(len_r);
    end
    tail_idx = IW'(used_len - LW'(1));
    err_k    = ({1'b0, err_r} > ERR_CAP) ? KW'(ERRORS_MAX) : KW'(err_r);
  end

  asm_char_mask #(
    .PATTERN_MAX (PATTERN_MAX),
    .LW          (LW)
  ) u_mask (
    .text_byte (in_stream.text_byte),
    .pat_words (pat_r),
    .used_len  (used_len),
    .cmask     (cmask)
  );

  assign advance         = !out_valid_r || out_stream.ready;
  assign fire            = in_valid_r && advance;
  assign in_ready        = !in_valid_r || advance;
  assign in_stream.ready = in_ready;

  // input register: the byte's match mask and end marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_stream.valid) begin
      in_mask_r <= cmask;
      in_last_r <= in_stream.last_of_string;
    end
  end

  asm_row_update #(
    .PATTERN_MAX    (PATTERN_MAX),
    .ERRORS_MAX     (ERRORS_MAX),
    .POSITION_WIDTH (POSITION_WIDTH),
    .IW             (IW),
    .KW             (KW)
  ) u_rows (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .cmask      (in_mask_r),
    .last       (in_last_r),
    .tail_idx   (tail_idx),
    .err_k      (err_k),
    .match_here (row_here),
    .match_seen (row_seen),
    .first_pos  (row_first)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_here_r  <= row_here;
      out_seen_r  <= row_seen;
      out_first_r <= row_first;
      out_done_r  <= in_last_r;
    end
  end

  assign out_stream.valid                = out_valid_r;
  assign out_stream.match_here           = out_here_r;
  assign out_stream.match_seen           = out_seen_r;
  assign out_stream.first_match_position = out_first_r;
  assign out_stream.string_done          = out_done_r;

  `ASM_ASSERT_NOW(a_ready_only_when_full, !in_ready, in_valid_r && out_valid_r && !out_stream.ready)
  `ASM_ASSERT_NOW(a_here_implies_seen, out_valid_r && out_here_r, out_seen_r)

endmodule

`default_nettype wire

// ----- tb/approximate_substring_matcher_core_tb.sv -----
`default_nettype none

module approximate_substring_matcher_core_tb;
  import asm_pkg::*;

  // cfg indexes past the last register; writes there must be dropped
  localparam logic [ASM_CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [ASM_CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       ends_string;
  } text_beat_t;

  typedef struct packed {
    logic                          here;
    logic                          seen;
    logic [ASM_POSITION_WIDTH-1:0] first_pos;
    logic                          done;
  } match_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                      cfg_we;
  logic [ASM_CFG_IDX_W-1:0]  cfg_index;
  logic [ASM_CFG_DATA_W-1:0] cfg_data;

  asm_in_if in_if ();
  asm_out_if #(.POS_W(ASM_POSITION_WIDTH)) out_if ();

  approximate_substring_matcher_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // matcher state as the block should hold it
  asm_pat_word_t                 pat_words [ASM_PATTERN_REGS];
  logic [ASM_LEN_W-1:0]          pat_len;
  logic [ASM_ERR_W-1:0]          err_lim;
  logic [ASM_PATTERN_MAX-1:0]    err_rows [ASM_ERRORS_MAX+1];
  logic [ASM_POSITION_WIDTH-1:0] byte_pos;
  logic                          seen_in_string;
  logic [ASM_POSITION_WIDTH-1:0] first_hit_pos;

  text_beat_t    text_beats_pending [$];
  match_report_t match_reports_due [$];
  match_report_t head_report;
  text_beat_t    next_beat;
  int            mismatch_count = 0;
  int            tx_gap_left;
  int            rx_stall_left;
  bit            idling_on = 1'b1;
  logic [7:0]    alpha_base;

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  function automatic void restart_string();
    int d;
    for (d = 0; d <= ASM_ERRORS_MAX; d++)
      err_rows[d] = (ASM_PATTERN_MAX'(1) << d) - 1'b1;
    byte_pos       = '0;
    seen_in_string = 1'b0;
    first_hit_pos  = '0;
  endfunction

  function automatic int used_len();
    if (pat_len == 0)
      return 1;
    if (pat_len > ASM_PATTERN_MAX)
      return ASM_PATTERN_MAX;
    return int'(pat_len);
  endfunction

  function automatic logic [7:0] pattern_byte(int i);
    return pat_words[i / ASM_BYTES_PER_REG][8 * (i % ASM_BYTES_PER_REG) +: 8];
  endfunction

  // bitap step with edits: one row per error count, all rows advanced together
  function automatic match_report_t predict_match(logic [7:0] text_byte, logic ends_string);
    logic [ASM_PATTERN_MAX-1:0] char_hits;
    logic [ASM_PATTERN_MAX-1:0] prev;
    logic [ASM_PATTERN_MAX-1:0] next_rows [ASM_ERRORS_MAX+1];
    int m, k, i, d;
    match_report_t rep;
    m = used_len();
    k = (err_lim > ASM_ERRORS_MAX) ? ASM_ERRORS_MAX : int'(err_lim);
    char_hits = '0;
    for (i = 0; i < m; i++)
      if (pattern_byte(i) == text_byte)
        char_hits[i] = 1'b1;
    for (d = 0; d <= ASM_ERRORS_MAX; d++) begin
      next_rows[d] = {err_rows[d][ASM_PATTERN_MAX-2:0], 1'b1} & char_hits;
      if (d > 0) begin
        prev = err_rows[d-1] | next_rows[d-1];
        next_rows[d] = next_rows[d] | {prev[ASM_PATTERN_MAX-2:0], 1'b1} | err_rows[d-1];
      end
    end
    for (d = 0; d <= ASM_ERRORS_MAX; d++)
      err_rows[d] = next_rows[d];
    rep.here = next_rows[k][m-1];
    if (rep.here && !seen_in_string) begin
      seen_in_string = 1'b1;
      first_hit_pos  = byte_pos;
    end
    rep.seen      = seen_in_string;
    rep.first_pos = first_hit_pos;
    rep.done      = ends_string;
    if (byte_pos != '1)
      byte_pos++;
    if (ends_string)
      restart_string();
    return rep;
  endfunction

  task automatic write_reg(logic [ASM_CFG_IDX_W-1:0] idx, asm_pat_word_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ASM_CFG_PAT0, ASM_CFG_PAT1, ASM_CFG_PAT2, ASM_CFG_PAT3: pat_words[idx[1:0]] = val;
      ASM_CFG_LEN: pat_len = val[ASM_LEN_W-1:0];
      ASM_CFG_ERR: err_lim = val[ASM_ERR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_until_quiet();
    do @(negedge clk);
    while (text_beats_pending.size() != 0 || in_if.valid || match_reports_due.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic push_beat(logic [7:0] b, logic ends_string);
    text_beat_t t;
    t.text_byte   = b;
    t.ends_string = ends_string;
    text_beats_pending.push_back(t);
  endtask

  task automatic push_text(string s, bit close);
    int i;
    for (i = 0; i < s.len(); i++)
      push_beat(s[i], close && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 15) == 0)
      return 8'($urandom_range(0, 255));
    return alpha_base + 8'($urandom_range(0, 3));
  endfunction

  // text from a small alphabet with damaged copies of the pattern mixed in
  task automatic push_noisy_text(int n, bit close);
    int m, i, cnt;
    m = used_len();
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 3) == 0) begin
        for (i = 0; i < m && cnt < n; i++) begin
          case ($urandom_range(0, 11))
            0: ;
            1: begin
              push_beat(noise_char(), 1'b0);
              push_beat(pattern_byte(i), 1'b0);
              cnt += 2;
            end
            2: begin
              push_beat(noise_char(), 1'b0);
              cnt++;
            end
            default: begin
              push_beat(pattern_byte(i), 1'b0);
              cnt++;
            end
          endcase
        end
      end else begin
        push_beat(noise_char(), 1'b0);
        cnt++;
      end
    end
    text_beats_pending[text_beats_pending.size()-1].ends_string = close;
  endtask

  // driver: predicts each accepted beat, then presents the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid          <= 1'b0;
      in_if.text_byte      <= '0;
      in_if.last_of_string <= 1'b0;
      tx_gap_left          <= 0;
    end else begin
      if (in_if.valid && in_if.ready)
        match_reports_due.push_back(predict_match(in_if.text_byte, in_if.last_of_string));
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap_left != 0) begin
          tx_gap_left <= tx_gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (text_beats_pending.size() != 0) begin
          if (idling_on && $urandom_range(0, 9) == 0) begin
            tx_gap_left <= $urandom_range(0, 10);
            in_if.valid <= 1'b0;
          end else begin
            next_beat = text_beats_pending.pop_front();
            in_if.valid          <= 1'b1;
            in_if.text_byte      <= next_beat.text_byte;
            in_if.last_of_string <= next_beat.ends_string;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready  <= 1'b0;
      rx_stall_left <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (match_reports_due.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          head_report = match_reports_due.pop_front();
          if (out_if.match_here !== head_report.here)
            flag_mismatch($sformatf("match_here %b, want %b", out_if.match_here,
                                    head_report.here));
          if (out_if.match_seen !== head_report.seen)
            flag_mismatch($sformatf("match_seen %b, want %b", out_if.match_seen,
                                    head_report.seen));
          if (out_if.first_match_position !== head_report.first_pos)
            flag_mismatch($sformatf("first_match_position %0d, want %0d",
                                    out_if.first_match_position, head_report.first_pos));
          if (out_if.string_done !== head_report.done)
            flag_mismatch($sformatf("string_done %b, want %b", out_if.string_done,
                                    head_report.done));
        end
      end
      if (rx_stall_left != 0) begin
        rx_stall_left <= rx_stall_left - 1;
        out_if.ready  <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        rx_stall_left <= $urandom_range(0, 10);
        out_if.ready  <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int ph, w, j, n, budget;
    bit wide_random;
    asm_pat_word_t word;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (w = 0; w < ASM_PATTERN_REGS; w++)
      pat_words[w] = '0;
    pat_len = 1;
    err_lim = 0;
    restart_string();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: one-byte pattern of 0x00, so a match at byte 0
    @(negedge clk);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b1);
    wait_until_quiet();

    write_reg(ASM_CFG_PAT0, {32'h0, "dcba"});
    write_reg(ASM_CFG_LEN, 64'hFFFF_FFFF_FFFF_FFC4);
    write_reg(ASM_CFG_ERR, 64'hFFFF_FFFF_FFFF_FFF0);
    @(negedge clk);
    push_text("zabcd", 1'b1);
    wait_until_quiet();

    write_reg(ASM_CFG_ERR, 64'hFFFF_FFFF_FFFF_FFF1);
    @(negedge clk);
    push_text("abxd", 1'b1);
    push_text("acd", 1'b1);
    push_text("ab", 1'b0);
    wait_until_quiet();

    // config change in the middle of a string; rows carry over
    write_reg(ASM_CFG_ERR, 64'h0123_4567_89AB_CDE2);
    write_reg(CFG_IDX_SPARE_A, '1);
    write_reg(CFG_IDX_SPARE_B, '1);
    @(negedge clk);
    push_text("d", 1'b1);
    wait_until_quiet();

    write_reg(ASM_CFG_LEN, 64'hFFFF_FFFF_FFFF_FFC0);
    @(negedge clk);
    push_text("ba", 1'b1);
    wait_until_quiet();

    // length and error limit beyond their maximums
    write_reg(ASM_CFG_PAT1, 64'h6261_6362_6164_6362);
    write_reg(ASM_CFG_PAT2, '1);
    write_reg(ASM_CFG_PAT3, '0);
    write_reg(ASM_CFG_LEN, 64'hFFFF_FFFF_FFFF_FFE8);
    write_reg(ASM_CFG_ERR, '1);
    @(negedge clk);
    push_text("abc", 1'b1);
    push_beat(8'hFF, 1'b1);

    for (ph = 0; ph < 24; ph++) begin
      wait_until_quiet();
      if (ph == 20)
        idling_on = 1'b0;
      alpha_base  = 8'($urandom_range(0, 255));
      wide_random = ($urandom_range(0, 3) == 0);
      for (w = 0; w < ASM_PATTERN_REGS; w++) begin
        if (ph == 0 || $urandom_range(0, 3) != 0) begin
          word = {$urandom, $urandom};
          if (!wide_random)
            for (j = 0; j < ASM_BYTES_PER_REG; j++)
              word[8 * j +: 8] = alpha_base + 8'($urandom_range(0, 3));
          write_reg(ASM_CFG_IDX_W'(ASM_CFG_PAT0 + w), word);
        end
      end
      word = {$urandom, $urandom};
      case ($urandom_range(0, 19))
        0: word[ASM_LEN_W-1:0] = 0;
        1: word[ASM_LEN_W-1:0] = ASM_PATTERN_MAX;
        2: word[ASM_LEN_W-1:0] = ASM_LEN_W'($urandom_range(ASM_PATTERN_MAX + 1, 63));
        3, 4, 5: word[ASM_LEN_W-1:0] = ASM_LEN_W'($urandom_range(9, ASM_PATTERN_MAX - 1));
        default: word[ASM_LEN_W-1:0] = ASM_LEN_W'($urandom_range(1, 8));
      endcase
      write_reg(ASM_CFG_LEN, word);
      word = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: word[ASM_ERR_W-1:0] = ASM_ERRORS_MAX;
        1: word[ASM_ERR_W-1:0] = ASM_ERR_W'($urandom_range(ASM_ERRORS_MAX + 1, 15));
        default: word[ASM_ERR_W-1:0] = ASM_ERR_W'($urandom_range(0, 3));
      endcase
      write_reg(ASM_CFG_ERR, word);
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                  {$urandom, $urandom});
      @(negedge clk);
      budget = 80;
      while (budget > 0) begin
        n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
        if (n >= budget) begin
          n = budget;
          // a phase may stop mid-string so the next config lands inside it
          push_noisy_text(n, ph == 23 || $urandom_range(0, 2) != 0);
        end else begin
          push_noisy_text(n, 1'b1);
        end
        budget -= n;
      end
    end

    wait_until_quiet();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ----- approximate_substring_matcher_core.f -----
+incdir+design
design/asm_pkg.sv
design/asm_stream_ifs.sv
design/asm_char_mask.sv
design/asm_row_update.sv
design/approximate_substring_matcher_core.sv
tb/approximate_substring_matcher_core_tb.sv
